// File: rtl/bss_pkg.sv
package bss_pkg;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SELECT,
        ST_FINISH
    } bss_state_t;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned TOTAL_W  = 7;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned MEAN_W   = 16;
    localparam logic [SAMPLE_W-1:0] MIN_START = 8'hFF;
    localparam logic [SAMPLE_W-1:0] MAX_START = 8'h00;

endpackage

// File: rtl/byte_set_statistics_core.sv
// Byte set statistics core.
//
// The block takes one unsigned byte sample per beat on the command channel.
// A beat is accepted at a rising edge with start high and busy low. A beat
// with last high closes the set. Up to MAX_SAMPLES samples are kept in an
// on-chip sample memory; any further samples in the same set are dropped and
// reported through overflow.
//
// Samples load at one beat per cycle while busy is low. After the closing
// beat the core raises busy and finds the median by a bitwise radix select
// that sweeps the sample memory once per result bit: 8 sweeps, each bound
// by the single read port of the memory. A bit-serial divider works out
// the 8.8 mean in parallel, and the core waits for it to finish. The
// result appears for exactly one cycle, marked by done; busy is low again
// in that same cycle. The receiver cannot stall the core, so a result that
// is not taken in its done cycle is lost.
//
// Reset clears the control state and the running accumulators. The sample
// memory needs no clearing: every entry is written before it is read.
module byte_set_statistics_core #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [7:0] sample,
    input  logic       last,
    output logic       busy,
    output logic       done,
    output logic [7:0] min_value,
    output logic [7:0] max_value,
    output logic [7:0] mean_whole,
    output logic [7:0] mean_frac,
    output logic [7:0] median_value,
    output logic [6:0] sample_total,
    output logic       overflow
);

    // Count width must hold MAX_SAMPLES itself; address width indexes the store.
    localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    // The running sum needs room for MAX_SAMPLES full-scale bytes.
    localparam int unsigned SW  = bss_pkg::SAMPLE_W + CW;
    // The divider works on the sum shifted up by the fraction width.
    localparam int unsigned DW  = SW + bss_pkg::FRAC_W;
    localparam int unsigned SCW = $clog2(DW + 1);

    bss_pkg::bss_state_t state_reg, state_next;

    // Running accumulators for the set being loaded.
    logic [CW-1:0] count_reg;
    logic [7:0]    min_reg;
    logic [7:0]    max_reg;
    logic [SW-1:0] sum_reg;
    logic          drop_reg;

    // Values captured from the closing beat.
    logic [CW-1:0] n_reg;
    logic [7:0]    min_out_reg;
    logic [7:0]    max_out_reg;
    logic [6:0]    total_reg;
    logic          ovf_reg;
    logic          done_reg;

    // Radix select state.
    logic [CW-1:0] k_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] issue_reg;
    logic [7:0]    pfx_reg;
    logic [7:0]    msk_reg;
    logic [2:0]    bit_reg;
    logic          rd_vld_reg;

    // Divider state.
    logic [DW-1:0]  dd_reg;
    logic [CW-1:0]  rem_reg;
    logic [SCW-1:0] step_reg;
    logic           div_run_reg;

    // Sample memory with a registered read port.
    logic [7:0] mem [MAX_SAMPLES];
    logic [7:0] rd_data_reg;

    logic          accept;
    logic          store_ok;
    logic          close_set;
    logic [CW-1:0] count_upd;
    logic [7:0]    min_upd;
    logic [7:0]    max_upd;
    logic [SW-1:0] sum_upd;
    logic          drop_upd;
    logic          issuing;
    logic          pass_done;
    logic          last_pass;
    logic [7:0]    bit_sel;
    logic          match;
    logic [CW:0]   trial;
    logic          trial_ge;

    assign accept    = start && !busy;
    assign close_set = accept && last;
    assign store_ok  = count_reg < CW'(MAX_SAMPLES);

    // Next values of the accumulators once this beat is folded in.
    always_comb
    begin
        count_upd = count_reg;
        min_upd   = min_reg;
        max_upd   = max_reg;
        sum_upd   = sum_reg;
        drop_upd  = drop_reg;
        if (store_ok)
        begin
            count_upd = count_reg + CW'(1);
            if (sample < min_reg)
            begin
                min_upd = sample;
            end
            if (sample > max_reg)
            begin
                max_upd = sample;
            end
            sum_upd = sum_reg + SW'(sample);
        end
        else
        begin
            drop_upd = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= bss_pkg::MIN_START;
            max_reg   <= bss_pkg::MAX_START;
            sum_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                count_reg <= '0;
                min_reg   <= bss_pkg::MIN_START;
                max_reg   <= bss_pkg::MAX_START;
                sum_reg   <= '0;
                drop_reg  <= 1'b0;
            end
            else
            begin
                count_reg <= count_upd;
                min_reg   <= min_upd;
                max_reg   <= max_upd;
                sum_reg   <= sum_upd;
                drop_reg  <= drop_upd;
            end
        end
    end

    // The store port writes during loading and reads during the select sweeps.
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        rd_data_reg <= mem[issue_reg[AW-1:0]];
    end

    // Radix select: each sweep counts the entries that share the prefix found
    // so far and have the current bit set, then decides that bit of the median.
    assign issuing   = (state_reg == bss_pkg::ST_SELECT) && (issue_reg != n_reg);
    assign pass_done = (state_reg == bss_pkg::ST_SELECT) && (issue_reg == n_reg)
                       && !rd_vld_reg;
    assign last_pass = (bit_reg == 3'd0);
    assign bit_sel   = 8'b1 << bit_reg;
    assign match     = ((rd_data_reg & msk_reg) == pfx_reg) && rd_data_reg[bit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issuing;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_set)
        begin
            n_reg       <= count_upd;
            k_reg       <= count_upd >> 1;
            cnt_reg     <= '0;
            issue_reg   <= '0;
            pfx_reg     <= '0;
            msk_reg     <= '0;
            bit_reg     <= 3'd7;
            min_out_reg <= min_upd;
            max_out_reg <= max_upd;
            total_reg   <= 7'(count_upd);
            ovf_reg     <= drop_upd;
        end
        else
        begin
            if (issuing)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (rd_vld_reg && match)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (pass_done)
            begin
                if (k_reg < cnt_reg)
                begin
                    pfx_reg <= pfx_reg | bit_sel;
                end
                else
                begin
                    k_reg <= k_reg - cnt_reg;
                end
                msk_reg   <= msk_reg | bit_sel;
                cnt_reg   <= '0;
                issue_reg <= '0;
                bit_reg   <= bit_reg - 3'd1;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle; the quotient replaces
    // the dividend bit by bit in the same shift register. The remainder is
    // always below n, so it fits the count width.
    assign trial    = {rem_reg, dd_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, n_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_run_reg <= 1'b0;
        end
        else if (close_set)
        begin
            div_run_reg <= 1'b1;
        end
        else if (div_run_reg && (step_reg == SCW'(1)))
        begin
            div_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close_set)
        begin
            dd_reg   <= {sum_upd, {bss_pkg::FRAC_W{1'b0}}};
            rem_reg  <= '0;
            step_reg <= SCW'(DW);
        end
        else if (div_run_reg)
        begin
            rem_reg  <= trial_ge ? CW'(trial - {1'b0, n_reg}) : trial[CW-1:0];
            dd_reg   <= {dd_reg[DW-2:0], trial_ge};
            step_reg <= step_reg - SCW'(1);
        end
    end

    // Control.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bss_pkg::ST_LOAD:
            begin
                if (close_set)
                begin
                    state_next = bss_pkg::ST_SELECT;
                end
            end
            bss_pkg::ST_SELECT:
            begin
                if (pass_done && last_pass)
                begin
                    state_next = bss_pkg::ST_FINISH;
                end
            end
            bss_pkg::ST_FINISH:
            begin
                if (!div_run_reg)
                begin
                    state_next = bss_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = bss_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != bss_pkg::ST_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bss_pkg::ST_LOAD;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == bss_pkg::ST_FINISH) && !div_run_reg;
        end
    end

    // Result fields hold until the next set closes, which is after done.
    assign done         = done_reg;
    assign min_value    = min_out_reg;
    assign max_value    = max_out_reg;
    assign mean_whole   = dd_reg[bss_pkg::MEAN_W-1:bss_pkg::FRAC_W];
    assign mean_frac    = dd_reg[bss_pkg::FRAC_W-1:0];
    assign median_value = pfx_reg;
    assign sample_total = total_reg;
    assign overflow     = ovf_reg;

endmodule

// File: tb/byte_set_statistics_core_test.sv
`timescale 1ns / 1ps

module byte_set_statistics_core_test;

    localparam int unsigned VALUE_W     = bss_pkg::SAMPLE_W;
    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned ITEMS       = 1250;
    // The median search sweeps the store eight times, so the drain time below
    // scales with the store depth.
    localparam int unsigned DRAIN_CYCLES = 8 * STORE_DEPTH + 40;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // How the sample values of a random set are drawn.
    typedef enum {
        FILL_ANY,
        FILL_LOW,
        FILL_HIGH,
        FILL_EDGES,
        FILL_FLAT
    } fill_style_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               closes;
    } beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0]          lo;
        logic [VALUE_W-1:0]          hi;
        logic [VALUE_W-1:0]          whole;
        logic [VALUE_W-1:0]          frac;
        logic [VALUE_W-1:0]          mid;
        logic [bss_pkg::TOTAL_W-1:0] count;
        logic                        dropped;
    } set_stats_t;

    logic               clk    = 1'b0;
    logic               rst_n  = 1'b0;
    logic               start  = 1'b0;
    logic [VALUE_W-1:0] sample = '0;
    logic               last   = 1'b0;
    logic               busy;
    logic               done;
    logic [7:0]         min_value;
    logic [7:0]         max_value;
    logic [7:0]         mean_whole;
    logic [7:0]         mean_frac;
    logic [7:0]         median_value;
    logic [6:0]         sample_total;
    logic               overflow;

    beat_t       beats_to_send[$];
    set_stats_t  stats_due[$];

    // Predictor state for the set that is being loaded.
    int unsigned        set_hist[256];
    int unsigned        set_count;
    int unsigned        set_sum;
    logic [VALUE_W-1:0] set_min;
    logic [VALUE_W-1:0] set_max;
    logic               set_dropped;

    int unsigned beats_taken  = 0;
    int unsigned quiet_from   = 0;
    int unsigned gap_left     = 0;
    int unsigned idle_odds    = 0;
    int unsigned mode_left    = 0;
    int unsigned results_seen = 0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;

    byte_set_statistics_core #(
        .MAX_SAMPLES(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .sample(sample),
        .last(last),
        .busy(busy),
        .done(done),
        .min_value(min_value),
        .max_value(max_value),
        .mean_whole(mean_whole),
        .mean_frac(mean_frac),
        .median_value(median_value),
        .sample_total(sample_total),
        .overflow(overflow)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t, result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Restores the running statistics to their state after reset.
    task automatic clear_set();
        for (int v = 0; v < 256; v++)
            set_hist[v] = 0;
        set_count   = 0;
        set_sum     = 0;
        set_min     = bss_pkg::MIN_START;
        set_max     = bss_pkg::MAX_START;
        set_dropped = 1'b0;
    endtask

    // Folds one accepted beat into the running statistics. A beat that
    // closes the set produces the expected result and starts a fresh set.
    task automatic absorb_sample(input logic [VALUE_W-1:0] value, input logic closes);
        set_stats_t  stats;
        int unsigned rank;
        int unsigned seen;
        int unsigned scaled;
        logic        found;
        if (set_count < STORE_DEPTH)
        begin
            set_hist[value]++;
            set_count++;
            set_sum += 32'(value);
            if (value < set_min)
                set_min = value;
            if (value > set_max)
                set_max = value;
        end
        else
        begin
            // The store is full: the sample is lost but the set is flagged.
            set_dropped = 1'b1;
        end
        if (closes)
        begin
            // The median is the value at descending rank count/2, so walk the
            // histogram from the top until more than that many are passed.
            rank  = set_count / 2;
            seen  = 0;
            found = 1'b0;
            stats.mid = '0;
            for (int v = 255; v >= 0; v--)
            begin
                seen += set_hist[v];
                if (!found && seen > rank)
                begin
                    stats.mid = v[VALUE_W-1:0];
                    found     = 1'b1;
                end
            end
            scaled        = (set_sum << 8) / set_count;
            stats.lo      = set_min;
            stats.hi      = set_max;
            stats.whole   = scaled[15:8];
            stats.frac    = scaled[7:0];
            stats.count   = set_count[bss_pkg::TOTAL_W-1:0];
            stats.dropped = set_dropped;
            stats_due.push_back(stats);
            clear_set();
        end
    endtask

    task automatic queue_beat(input logic [VALUE_W-1:0] value, input logic closes);
        beat_t beat;
        beat.value  = value;
        beat.closes = closes;
        beats_to_send.push_back(beat);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input fill_style_t style,
                                                      input logic [VALUE_W-1:0] flat);
        case (style)
            FILL_LOW:   return VALUE_W'($urandom_range(3));
            FILL_HIGH:  return VALUE_W'($urandom_range(255, 252));
            FILL_EDGES: return $urandom_range(1) ? 8'hFF : 8'h00;
            FILL_FLAT:  return ($urandom_range(3) == 0) ? VALUE_W'($urandom_range(255))
                                                        : flat;
            default:    return VALUE_W'($urandom_range(255));
        endcase
    endfunction

    // Queues one whole set of random content, closed by its final beat.
    task automatic queue_set(input int unsigned len);
        fill_style_t        style;
        logic [VALUE_W-1:0] flat;
        if ($urandom_range(1))
            style = FILL_ANY;
        else
            style = fill_style_t'($urandom_range(4));
        flat = VALUE_W'($urandom_range(255));
        for (int unsigned i = 0; i < len; i++)
            queue_beat(pick_value(style, flat), i == len - 1);
    endtask

    // Driver. A beat is taken at an edge where start is high and busy is low;
    // it is then held until taken, and idle gaps are only opened after a take.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic  taken;
        beat_t beat;
        if (!rst_n)
        begin
            start  <= 1'b0;
            sample <= '0;
            last   <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                absorb_sample(sample, last);
                beats_taken++;
                // Idling comes in modes: none, frequent or occasional bursts.
                if (mode_left == 0)
                begin
                    case ($urandom_range(2))
                        0:       idle_odds = 0;
                        1:       idle_odds = 2;
                        default: idle_odds = 8;
                    endcase
                    mode_left = $urandom_range(80, 20);
                end
                else
                begin
                    mode_left--;
                end
                if (beats_taken < quiet_from && idle_odds != 0
                        && $urandom_range(idle_odds - 1) == 0)
                    gap_left = $urandom_range(12, 1);
            end
            if (!start || taken)
            begin
                if (gap_left != 0 || beats_to_send.size() == 0)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    beat = beats_to_send.pop_front();
                    start  <= 1'b1;
                    sample <= beat.value;
                    last   <= beat.closes;
                end
            end
        end
    end

    // Monitor. The core cannot be held off, so every done cycle is a result.
    always @(posedge clk)
    begin : monitor
        set_stats_t due;
        if (rst_n && done)
        begin
            if (stats_due.size() == 0)
            begin
                report_mismatch("result with no closed set waiting");
            end
            else
            begin
                due = stats_due.pop_front();
                check_field("min_value", 32'(min_value), 32'(due.lo));
                check_field("max_value", 32'(max_value), 32'(due.hi));
                check_field("mean_whole", 32'(mean_whole), 32'(due.whole));
                check_field("mean_frac", 32'(mean_frac), 32'(due.frac));
                check_field("median_value", 32'(median_value), 32'(due.mid));
                check_field("sample_total", 32'(sample_total), 32'(due.count));
                check_field("overflow", 32'(overflow), 32'(due.dropped));
            end
            results_seen++;
        end
    end

    // Watchdog: a hung core or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("byte_set_statistics_core: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned roll;
        int unsigned len;
        clear_set();

        // Directed sets: single samples at both extremes, an even count whose
        // median is the lower middle value, ties, and halves in the mean.
        queue_beat(8'd0, 1'b1);
        queue_beat(8'd255, 1'b1);
        queue_beat(8'd255, 1'b0);
        queue_beat(8'd0, 1'b1);
        queue_beat(8'd1, 1'b0);
        queue_beat(8'd0, 1'b1);
        queue_beat(8'd10, 1'b0);
        queue_beat(8'd200, 1'b0);
        queue_beat(8'd30, 1'b0);
        queue_beat(8'd40, 1'b1);
        queue_beat(8'd1, 1'b0);
        queue_beat(8'd2, 1'b0);
        queue_beat(8'd3, 1'b1);
        queue_beat(8'd128, 1'b0);
        queue_beat(8'd127, 1'b0);
        queue_beat(8'd128, 1'b0);
        queue_beat(8'd255, 1'b0);
        queue_beat(8'd0, 1'b1);
        queue_beat(8'd255, 1'b0);
        queue_beat(8'd255, 1'b0);
        queue_beat(8'd255, 1'b1);

        // A set that fills the store exactly, one that drops its closing
        // beat, and one that drops several beats before closing.
        queue_set(STORE_DEPTH);
        queue_set(STORE_DEPTH + 1);
        queue_set(STORE_DEPTH + 6);

        // Random sets, mostly short since the core's latency grows with the
        // set size, with a few long ones around the store limit.
        while (beats_to_send.size() < ITEMS)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
                len = $urandom_range(6, 1);
            else if (roll < 92)
                len = $urandom_range(32, 7);
            else
                len = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH - 4);
            queue_set(len);
        end
        // The last part of the run goes without idling.
        quiet_from = beats_to_send.size() * 85 / 100;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_to_send.size() != 0 || start)
            @(posedge clk);
        while (stats_due.size() != 0)
            @(posedge clk);
        // Catch any stray result after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("byte_set_statistics_core: match");
        else
            $display("byte_set_statistics_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/bss_pkg.sv
rtl/byte_set_statistics_core.sv
tb/byte_set_statistics_core_test.sv
